// ----- design/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the byte-oriented stream cipher: request
// and response payloads, sequencer states and table write bundle.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int ADDR_W      = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_W       = 64;
   localparam logic [ADDR_W-1:0] LAST_INDEX = 8'hFF;

   localparam logic ACTION_RESTART = 1'b0;
   localparam logic ACTION_DATA    = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] data_in;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } res_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_WR_A,
      ST_WR_B,
      ST_KS
   } state_type;

endpackage

// ----- design/rc4_stream_cipher.sv -----
// Data request: steps RD_A, RD_B, WR_A, WR_B and KS, holding in KS while the
// response register is stalled; the response is registered. No new request is
// taken before the return to IDLE; the table has single read and write ports.
// Restart request: identity fill plus 256 swaps before the next request is
// taken; no response is given. Reset: synchronous; an identity fill of the
// table runs with req_ready low. Key register writes are taken at any time.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// Stream cipher top level: key register, response register and the table
// sequencer.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rc4_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rc4_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rc4_pkg::KEY_W-1:0]  csr_data
);

   logic [rc4_pkg::KEY_W-1:0] key_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rc4_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   rc4_pkg::res_type          res;
   logic                      res_busy;

   assign csr_ready = 1'b1;
   assign res_busy  = rsp_valid_ff && !rsp_ready;

   rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .key_word  (key_ff),
      .res_busy  (res_busy),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         key_ff <= csr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/rc4_perm_ram.sv -----
// ----------------------------------------------------------------------------
// rc4_perm_ram
// Permutation table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
   input  logic                        clock,
   input  rc4_pkg::wr_type             wr,
   input  logic                        rd_en,
   input  logic [rc4_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [rc4_pkg::TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4_ctrl
// Table sequencer: identity fill, key schedule swaps and per-byte
// keystream generation around the permutation table.
// ----------------------------------------------------------------------------
module rc4_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rc4_pkg::req_type                  req_data,
   input  logic [rc4_pkg::KEY_W-1:0]         key_word,
   input  logic                              res_busy,
   output rc4_pkg::res_type                  res
);

   rc4_pkg::state_type state_ff, state_in;
   logic [rc4_pkg::ADDR_W-1:0] a_ff, a_in;
   logic [rc4_pkg::ADDR_W-1:0] b_ff, b_in;
   logic [rc4_pkg::ADDR_W-1:0] ia_ff, ia_in;
   logic [rc4_pkg::ADDR_W-1:0] ib_ff, ib_in;
   logic [7:0]                 va_ff, va_in;
   logic [7:0]                 vb_ff, vb_in;
   logic                       key_mode_ff, key_mode_in;
   logic                       fwd_ff, fwd_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;

   rc4_pkg::wr_type            wr;
   logic                       rd_en;
   logic [rc4_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                 rd_data;
   logic [7:0]                 key_byte;
   logic [rc4_pkg::ADDR_W-1:0] ks_addr;
   logic [7:0]                 ks;

   rc4_perm_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign key_byte = key_word[{a_ff[2:0], 3'b000} +: 8];
   assign ks_addr  = va_ff + vb_ff;
   assign ks       = fwd_ff ? va_ff : rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rc4_pkg::ST_FILL;
         a_ff        <= '0;
         ia_ff       <= '0;
         ib_ff       <= '0;
         key_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         a_ff        <= a_in;
         ia_ff       <= ia_in;
         ib_ff       <= ib_in;
         key_mode_ff <= key_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      fwd_ff  <= fwd_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      ia_in       = ia_ff;
      ib_in       = ib_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      key_mode_in = key_mode_ff;
      fwd_in      = fwd_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      wr          = '0;
      rd_en       = 1'b0;
      rd_addr     = a_ff;
      req_ready   = 1'b0;
      res         = '0;

      case (state_ff)
         rc4_pkg::ST_FILL: begin
            wr.en   = 1'b1;
            wr.addr = a_ff;
            wr.data = a_ff;
            a_in    = a_ff + 8'd1;
            if (a_ff == rc4_pkg::LAST_INDEX) begin
               if (key_mode_ff) begin
                  ib_in    = '0;
                  state_in = rc4_pkg::ST_RD_A;
               end else begin
                  state_in = rc4_pkg::ST_IDLE;
               end
            end
         end
         rc4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.action == rc4_pkg::ACTION_RESTART) begin
                  key_mode_in = 1'b1;
                  a_in        = '0;
                  state_in    = rc4_pkg::ST_FILL;
               end else begin
                  key_mode_in = 1'b0;
                  a_in        = ia_ff + 8'd1;
                  ia_in       = ia_ff + 8'd1;
                  byte_in     = req_data.data_in;
                  last_in     = req_data.end_of_chunk;
                  state_in    = rc4_pkg::ST_RD_A;
               end
            end
         end
         rc4_pkg::ST_RD_A: begin
            rd_en    = 1'b1;
            rd_addr  = a_ff;
            state_in = rc4_pkg::ST_RD_B;
         end
         rc4_pkg::ST_RD_B: begin
            va_in = rd_data;
            if (key_mode_ff) begin
               b_in = ib_ff + rd_data + key_byte;
            end else begin
               b_in = ib_ff + rd_data;
            end
            ib_in    = b_in;
            rd_en    = 1'b1;
            rd_addr  = b_in;
            state_in = rc4_pkg::ST_WR_A;
         end
         rc4_pkg::ST_WR_A: begin
            vb_in    = rd_data;
            wr.en    = 1'b1;
            wr.addr  = a_ff;
            wr.data  = rd_data;
            state_in = rc4_pkg::ST_WR_B;
         end
         rc4_pkg::ST_WR_B: begin
            wr.en   = 1'b1;
            wr.addr = b_ff;
            wr.data = va_ff;
            if (key_mode_ff) begin
               a_in = a_ff + 8'd1;
               if (a_ff == rc4_pkg::LAST_INDEX) begin
                  ia_in       = '0;
                  ib_in       = '0;
                  key_mode_in = 1'b0;
                  state_in    = rc4_pkg::ST_IDLE;
               end else begin
                  state_in = rc4_pkg::ST_RD_A;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ks_addr;
               fwd_in   = (ks_addr == b_ff);
               state_in = rc4_pkg::ST_KS;
            end
         end
         rc4_pkg::ST_KS: begin
            if (!res_busy) begin
               res.valid            = 1'b1;
               res.payload.data_out = byte_ff ^ ks;
               res.payload.last_out = last_ff;
               state_in             = rc4_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rc4_pkg::ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == rc4_pkg::ST_FILL || state_ff == rc4_pkg::ST_WR_A ||
                 state_ff == rc4_pkg::ST_WR_B))
      else $error("table written outside a write step");

   assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (state_ff == rc4_pkg::ST_KS && !key_mode_ff))
      else $error("result raised outside keystream step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_WR_B && key_mode_ff && a_ff == rc4_pkg::LAST_INDEX)
      |=> (ia_ff == '0 && ib_ff == '0 && state_ff == rc4_pkg::ST_IDLE))
      else $error("indices not cleared after key schedule");

endmodule

// ----- verif/rc4_stream_cipher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Self-checking bench for the stream cipher. A table of directed requests
// is followed by random runs of data bytes and restarts under a series of
// keys. Each response is checked against a table value or a cycle-free
// model of the permutation and indices, with random idling on both channels.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 176;
   localparam int SCHEDULE_WAIT = 1400;

   typedef struct {
      rc4_pkg::req_type req;
      bit               fixed;
      rc4_pkg::rsp_type want;
   } step_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   rc4_pkg::req_type          req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rc4_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [rc4_pkg::KEY_W-1:0] csr_data  = '0;

   logic [7:0]                sbox_model [0:rc4_pkg::TABLE_DEPTH-1];
   logic [7:0]                ia_model;
   logic [7:0]                ib_model;
   logic [rc4_pkg::KEY_W-1:0] key_model;
   rc4_pkg::rsp_type          cipher_out_q [$];
   rc4_pkg::rsp_type          want_rsp;

   int  fail_count   = 0;
   int  req_count    = 0;
   int  restart_count = 0;
   int  key_count    = 0;
   int  rsp_count    = 0;
   int  cycle_count  = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   bit  calm         = 1'b0;

   localparam logic [rc4_pkg::KEY_W-1:0] KEY_LIST [0:6] = '{
      64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hEFCD_AB89_6745_2301, 64'h0,
      64'h8000_0000_0000_0001, 64'h0, 64'h0
   };

   step_row_type directed_rows [0:13] = '{
      '{'{rc4_pkg::ACTION_DATA,    8'h00, 1'b0}, 1'b1, '{8'h02, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'hFF, 1'b1}, 1'b1, '{8'hFA, 1'b1}},
      '{'{rc4_pkg::ACTION_DATA,    8'h5A, 1'b0}, 1'b1, '{8'h5D, 1'b0}},
      '{'{rc4_pkg::ACTION_RESTART, 8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'h80, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'h01, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_RESTART, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_RESTART, 8'h5A, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'h00, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'hAA, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::ACTION_DATA,    8'h55, 1'b1}, 1'b0, '{8'h00, 1'b0}}
   };

   rc4_stream_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   task automatic clear_cipher_model();
      for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) sbox_model[n] = n[7:0];
      ia_model = '0;
      ib_model = '0;
   endtask

   task automatic schedule_key_model();
      logic [7:0] j;
      logic [7:0] t;
      clear_cipher_model();
      j = '0;
      for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) begin
         j = j + sbox_model[n] + key_model[8 * (n % 8) +: 8];
         t = sbox_model[n];
         sbox_model[n] = sbox_model[j];
         sbox_model[j] = t;
      end
      ia_model = '0;
      ib_model = '0;
   endtask

   task automatic cipher_byte_model(input rc4_pkg::req_type r,
                                    output rc4_pkg::rsp_type res);
      logic [7:0] va;
      logic [7:0] vb;
      logic [7:0] sum;
      ia_model = ia_model + 8'd1;
      ib_model = ib_model + sbox_model[ia_model];
      va = sbox_model[ia_model];
      vb = sbox_model[ib_model];
      sbox_model[ia_model] = vb;
      sbox_model[ib_model] = va;
      sum = va + vb;
      res.data_out = r.data_in ^ sbox_model[sum];
      res.last_out = r.end_of_chunk;
   endtask

   task automatic send_request(input rc4_pkg::req_type r, input bit fixed,
                               input rc4_pkg::rsp_type lit);
      int               n_idle;
      rc4_pkg::rsp_type res;
      n_idle = 0;
      if (!calm && $urandom_range(99) < 28) n_idle = $urandom_range(1, 9);
      if (n_idle > 0) begin
         req_valid <= 1'b0;
         repeat (n_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      req_count++;
      if (r.action == rc4_pkg::ACTION_RESTART) begin
         schedule_key_model();
         restart_count++;
      end else begin
         cipher_byte_model(r, res);
         cipher_out_q.push_back(fixed ? lit : res);
      end
   endtask

   task automatic write_key(input logic [rc4_pkg::KEY_W-1:0] k);
      // hold until responses drain and any key schedule has run out
      req_valid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (SCHEDULE_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_model = k;
      key_count++;
   endtask

   task automatic random_phase(input int items);
      rc4_pkg::req_type r;
      for (int i = 0; i < items; i++) begin
         calm <= (req_count >= 500 && req_count < 700);
         r.data_in      = 8'($urandom);
         r.end_of_chunk = ($urandom_range(7) == 0);
         if (i == 0) begin
            r.action = ($urandom_range(1) == 0) ? rc4_pkg::ACTION_RESTART
                                                : rc4_pkg::ACTION_DATA;
         end else begin
            r.action = ($urandom_range(99) < 3) ? rc4_pkg::ACTION_RESTART
                                                : rc4_pkg::ACTION_DATA;
         end
         send_request(r, 1'b0, '0);
      end
   endtask

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (cipher_out_q.size() == 0) begin
            $error("unexpected response data_out %02h last_out %0b",
                   rsp_data.data_out, rsp_data.last_out);
            fail_count++;
         end else begin
            want_rsp = cipher_out_q.pop_front();
            if (rsp_data.data_out !== want_rsp.data_out) begin
               $error("data_out expected %02h actual %02h",
                      want_rsp.data_out, rsp_data.data_out);
               fail_count++;
            end
            if (rsp_data.last_out !== want_rsp.last_out) begin
               $error("last_out expected %0b actual %0b",
                      want_rsp.last_out, rsp_data.last_out);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off, no stalls while calm
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= 300) begin
         rsp_ready <= 1'b0;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 28);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clear_cipher_model();
      key_model = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

      foreach (KEY_LIST[p]) begin
         if (p == 1 || p == 5 || p == 6) write_key({$urandom, $urandom});
         else                            write_key(KEY_LIST[p]);
         random_phase(RANDOM_ITEMS);
      end

      req_valid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Ran %0d requests, %0d of them restarts, under %0d key settings.",
               req_count, restart_count, key_count);
      $display("Checked %0d responses, including a long receiver hold-off.", rsp_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
